/* src/sbca_pkg.sv */
// Shared field widths and result codes for the sample buffer cache.
package sbca_pkg;

   // Field widths
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 16;
   localparam int OUT_W    = 2;
   localparam int BIDX_W   = 6;
   localparam int OFF_W    = 10;
   localparam int FREED_W  = 7;
   localparam int LAG_W    = 8;
   localparam int FRAME_W  = 32;

   // Request opcodes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Result outcome codes
   localparam logic [OUT_W-1:0] OUTCOME_HIT      = 2'd0;
   localparam logic [OUT_W-1:0] OUTCOME_MISS     = 2'd1;
   localparam logic [OUT_W-1:0] OUTCOME_FALLBACK = 2'd2;
   localparam logic [OUT_W-1:0] OUTCOME_TICK     = 2'd3;

   // Lag register reset value
   localparam logic [LAG_W-1:0] LAG_RESET = 8'd1;

endpackage

/* src/sample_buffer_cache_aging.sv */
// Sample buffer cache: sorted used list walk, free list refill and frame aging.
//
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid / req_stall | opcode, rom_address, byte_length
//  rsp_    | out       | rsp_valid / rsp_stall | outcome, buffer_index, byte_offset,
//          |           |                       | fetch_address, freed_count
//  csr_    | in        | csr_valid / csr_ready | age_limit
//
// A lookup walks the used list with a read and a check state per entry examined; on a miss it
// claims the free-list head, unlinks it and writes its stamp, then links it after the last
// smaller entry or at the list head (or names a fallback), and ends in the output state. A
// tick walks the used list, pushes each aged buffer onto the free list, then closes the walk.
// The walk is bounded by the single registered read port of the link and stamp memories.
// Reset (synchronous, active high) rebuilds the free chain at once through per-entry
// written flags; no sweep. The block takes one request at a time; req_stall is high
// until the result has been moved into the output register, which holds under rsp_stall.
module sample_buffer_cache_aging #(
   parameter int NUM_BUFFERS  = 64,
   parameter int BUFFER_BYTES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [sbca_pkg::ADDR_W-1:0]       req_rom_address,
   input  logic [sbca_pkg::LEN_W-1:0]        req_byte_length,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sbca_pkg::OUT_W-1:0]        rsp_outcome,
   output logic [sbca_pkg::BIDX_W-1:0]       rsp_buffer_index,
   output logic [sbca_pkg::OFF_W-1:0]        rsp_byte_offset,
   output logic [sbca_pkg::ADDR_W-1:0]       rsp_fetch_address,
   output logic [sbca_pkg::FREED_W-1:0]      rsp_freed_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sbca_pkg::LAG_W-1:0]        csr_age_limit
);
   import sbca_pkg::*;

   localparam int IDX_W  = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int LINK_W = $clog2(NUM_BUFFERS + 1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_BUFFERS);
   localparam int CMP_W  = ADDR_W + 2;

   // Sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_L_RD  = 4'd1;
   localparam logic [3:0] S_L_CHK = 4'd2;
   localparam logic [3:0] S_M_0   = 4'd3;
   localparam logic [3:0] S_M_1   = 4'd4;
   localparam logic [3:0] S_M_2   = 4'd5;
   localparam logic [3:0] S_M_3   = 4'd6;
   localparam logic [3:0] S_M_4   = 4'd7;
   localparam logic [3:0] S_M_5   = 4'd8;
   localparam logic [3:0] S_M_6   = 4'd9;
   localparam logic [3:0] S_T_RD  = 4'd10;
   localparam logic [3:0] S_T_CHK = 4'd11;
   localparam logic [3:0] S_T_A   = 4'd12;
   localparam logic [3:0] S_T_B   = 4'd13;
   localparam logic [3:0] S_T_C   = 4'd14;
   localparam logic [3:0] S_OUT   = 4'd15;

   function automatic logic is_live(input logic [LINK_W-1:0] x);
      return x < NIL;
   endfunction

   function automatic logic [IDX_W-1:0] to_idx(input logic [LINK_W-1:0] x);
      return x[IDX_W-1:0];
   endfunction

   // Memories
   logic [LINK_W-1:0]  nx_mem [NUM_BUFFERS];
   logic [LINK_W-1:0]  pv_mem [NUM_BUFFERS];
   logic [ADDR_W-1:0]  st_mem [NUM_BUFFERS];
   logic [FRAME_W-1:0] lu_mem [NUM_BUFFERS];
   logic [NUM_BUFFERS-1:0] nxv_ff, pvv_ff;

   // Read port
   logic [IDX_W-1:0]   rd_addr, rd_addr_ff;
   logic [LINK_W-1:0]  nx_q, pv_q;
   logic [ADDR_W-1:0]  st_q;
   logic [FRAME_W-1:0] lu_q;
   logic               nxv_q, pvv_q;
   logic [LINK_W-1:0]  nx_rd, pv_rd;

   // Write ports
   logic               nx_we, pv_we, st_we, lu_we;
   logic [LINK_W-1:0]  nx_wa, pv_wa, nx_wd, pv_wd;
   logic [IDX_W-1:0]   st_wa, lu_wa;
   logic [ADDR_W-1:0]  st_wd;

   // Control and working registers
   logic [3:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LINK_W-1:0]  p_ff, p_in, last_ff, last_in, f_ff, f_in, nx_ff, nx_in;
   logic [LINK_W-1:0]  steps_ff, steps_in, freed_ff, freed_in;
   logic [LINK_W-1:0]  used_head_ff, used_head_in, free_head_ff, free_head_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [LAG_W-1:0]   lag_ff, lag_in;

   // Result staging and output register
   logic [OUT_W-1:0]   res_out_ff, res_out_in;
   logic [BIDX_W-1:0]  res_idx_ff, res_idx_in;
   logic [OFF_W-1:0]   res_off_ff, res_off_in;
   logic [ADDR_W-1:0]  res_fetch_ff, res_fetch_in;
   logic [FREED_W-1:0] res_freed_ff, res_freed_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]   rsp_out_ff;
   logic [BIDX_W-1:0]  rsp_idx_ff;
   logic [OFF_W-1:0]   rsp_off_ff;
   logic [ADDR_W-1:0]  rsp_fetch_ff;
   logic [FREED_W-1:0] rsp_freed_ff;
   logic               rsp_load;

   logic               hit, aged;
   logic [ADDR_W-1:0]  even_addr;

   // Resolve unwritten link entries to their reset values
   assign nx_rd = nxv_q ? nx_q : LINK_W'(rd_addr_ff) + LINK_W'(1);
   assign pv_rd = pvv_q ? pv_q : NIL;

   assign hit  = ({2'b00, addr_ff} + CMP_W'(len_ff))
                 <= ({2'b00, st_q} + CMP_W'(BUFFER_BYTES));
   assign aged = FRAME_W'(lu_q + FRAME_W'(lag_ff)) < frame_ff;
   assign even_addr = {addr_ff[ADDR_W-1:1], 1'b0};

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == S_OUT) && !(rsp_valid_ff && rsp_stall);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      p_in         = p_ff;
      last_in      = last_ff;
      f_in         = f_ff;
      nx_in        = nx_ff;
      steps_in     = steps_ff;
      freed_in     = freed_ff;
      used_head_in = used_head_ff;
      free_head_in = free_head_ff;
      frame_in     = frame_ff;
      lag_in       = lag_ff;
      res_out_in   = res_out_ff;
      res_idx_in   = res_idx_ff;
      res_off_in   = res_off_ff;
      res_fetch_in = res_fetch_ff;
      res_freed_in = res_freed_ff;
      rd_addr      = to_idx(p_ff);
      nx_we = 1'b0; nx_wa = f_ff; nx_wd = NIL;
      pv_we = 1'b0; pv_wa = f_ff; pv_wd = NIL;
      st_we = 1'b0; st_wa = to_idx(f_ff); st_wd = even_addr;
      lu_we = 1'b0; lu_wa = to_idx(f_ff);

      if (csr_valid) begin
         lag_in = csr_age_limit;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               addr_in      = req_rom_address;
               len_in       = req_byte_length;
               p_in         = used_head_ff;
               last_in      = NIL;
               steps_in     = '0;
               freed_in     = '0;
               res_out_in   = OUTCOME_HIT;
               res_idx_in   = '0;
               res_off_in   = '0;
               res_fetch_in = '0;
               res_freed_in = '0;
               state_in     = (req_opcode == OP_TICK) ? S_T_RD : S_L_RD;
            end
         end
         // Walk the sorted used list
         S_L_RD: begin
            if (!is_live(p_ff) || steps_ff == NIL) begin
               state_in = S_M_0;
            end else begin
               state_in = S_L_CHK;
            end
         end
         S_L_CHK: begin
            if (st_q > addr_ff) begin
               state_in = S_M_0;
            end else if (hit) begin
               lu_we      = 1'b1;
               lu_wa      = to_idx(p_ff);
               res_out_in = OUTCOME_HIT;
               res_idx_in = BIDX_W'(p_ff);
               res_off_in = OFF_W'(addr_ff - st_q);
               state_in   = S_OUT;
            end else begin
               last_in  = p_ff;
               p_in     = nx_rd;
               steps_in = steps_ff + LINK_W'(1);
               state_in = S_L_RD;
            end
         end
         // Claim the free-list head, or name a fallback
         S_M_0: begin
            rd_addr = to_idx(free_head_ff);
            f_in    = free_head_ff;
            if (!is_live(free_head_ff)) begin
               res_out_in = OUTCOME_FALLBACK;
               res_off_in = OFF_W'(addr_ff[0]);
               if (is_live(last_ff)) begin
                  res_idx_in = BIDX_W'(last_ff);
               end else if (is_live(used_head_ff)) begin
                  res_idx_in = BIDX_W'(used_head_ff);
               end else begin
                  res_idx_in = '0;
               end
               state_in = S_OUT;
            end else begin
               state_in = S_M_1;
            end
         end
         S_M_1: begin
            free_head_in = nx_rd;
            nx_we = is_live(pv_rd); nx_wa = pv_rd; nx_wd = nx_rd;
            pv_we = is_live(nx_rd); pv_wa = nx_rd; pv_wd = pv_rd;
            st_we = 1'b1;
            lu_we = 1'b1;
            res_out_in   = OUTCOME_MISS;
            res_idx_in   = BIDX_W'(f_ff);
            res_off_in   = OFF_W'(addr_ff[0]);
            res_fetch_in = even_addr;
            state_in     = is_live(last_ff) ? S_M_2 : S_M_5;
         end
         // Link after the last smaller entry
         S_M_2: begin
            rd_addr  = to_idx(last_ff);
            state_in = S_M_3;
         end
         S_M_3: begin
            nx_we = 1'b1; nx_wa = f_ff; nx_wd = nx_rd;
            pv_we = 1'b1; pv_wa = f_ff; pv_wd = last_ff;
            nx_in    = nx_rd;
            state_in = S_M_4;
         end
         S_M_4: begin
            pv_we = is_live(nx_ff); pv_wa = nx_ff; pv_wd = f_ff;
            nx_we = 1'b1; nx_wa = last_ff; nx_wd = f_ff;
            state_in = S_OUT;
         end
         // Link at the head of the used list
         S_M_5: begin
            nx_we = 1'b1; nx_wa = f_ff; nx_wd = used_head_ff;
            pv_we = 1'b1; pv_wa = f_ff; pv_wd = NIL;
            if (is_live(used_head_ff)) begin
               state_in = S_M_6;
            end else begin
               used_head_in = f_ff;
               state_in     = S_OUT;
            end
         end
         S_M_6: begin
            pv_we = 1'b1; pv_wa = used_head_ff; pv_wd = f_ff;
            used_head_in = f_ff;
            state_in     = S_OUT;
         end
         // Age the used list
         S_T_RD: begin
            if (!is_live(p_ff) || steps_ff == NIL) begin
               frame_in     = frame_ff + FRAME_W'(1);
               res_out_in   = OUTCOME_TICK;
               res_freed_in = FREED_W'(freed_ff);
               state_in     = S_OUT;
            end else begin
               state_in = S_T_CHK;
            end
         end
         S_T_CHK: begin
            f_in     = p_ff;
            p_in     = nx_rd;
            steps_in = steps_ff + LINK_W'(1);
            if (aged) begin
               if (used_head_ff == p_ff) begin
                  used_head_in = nx_rd;
               end
               nx_we = is_live(pv_rd); nx_wa = pv_rd; nx_wd = nx_rd;
               pv_we = is_live(nx_rd); pv_wa = nx_rd; pv_wd = pv_rd;
               freed_in = freed_ff + LINK_W'(1);
               state_in = is_live(free_head_ff) ? S_T_A : S_T_B;
            end else begin
               state_in = S_T_RD;
            end
         end
         S_T_A: begin
            rd_addr  = to_idx(free_head_ff);
            state_in = S_T_B;
         end
         S_T_B: begin
            nx_we = 1'b1; nx_wa = f_ff;
            pv_we = 1'b1; pv_wa = f_ff;
            if (is_live(free_head_ff)) begin
               nx_wd    = nx_rd;
               pv_wd    = free_head_ff;
               nx_in    = nx_rd;
               state_in = S_T_C;
            end else begin
               nx_wd        = NIL;
               pv_wd        = NIL;
               free_head_in = f_ff;
               state_in     = S_T_RD;
            end
         end
         S_T_C: begin
            pv_we = is_live(nx_ff); pv_wa = nx_ff; pv_wd = f_ff;
            nx_we = 1'b1; nx_wa = free_head_ff; nx_wd = f_ff;
            state_in = S_T_RD;
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the output register until the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_head_ff <= NIL;
         free_head_ff <= '0;
         frame_ff     <= '0;
         lag_ff       <= LAG_RESET;
         rsp_valid_ff <= 1'b0;
         nxv_ff       <= '0;
         pvv_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         used_head_ff <= used_head_in;
         free_head_ff <= free_head_in;
         frame_ff     <= frame_in;
         lag_ff       <= lag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (nx_we) begin
            nxv_ff[to_idx(nx_wa)] <= 1'b1;
         end
         if (pv_we) begin
            pvv_ff[to_idx(pv_wa)] <= 1'b1;
         end
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      len_ff       <= len_in;
      p_ff         <= p_in;
      last_ff      <= last_in;
      f_ff         <= f_in;
      nx_ff        <= nx_in;
      steps_ff     <= steps_in;
      freed_ff     <= freed_in;
      res_out_ff   <= res_out_in;
      res_idx_ff   <= res_idx_in;
      res_off_ff   <= res_off_in;
      res_fetch_ff <= res_fetch_in;
      res_freed_ff <= res_freed_in;
      if (rsp_load) begin
         rsp_out_ff   <= res_out_ff;
         rsp_idx_ff   <= res_idx_ff;
         rsp_off_ff   <= res_off_ff;
         rsp_fetch_ff <= res_fetch_ff;
         rsp_freed_ff <= res_freed_ff;
      end
   end

   // Link and stamp memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (nx_we) begin
         nx_mem[to_idx(nx_wa)] <= nx_wd;
      end
      if (pv_we) begin
         pv_mem[to_idx(pv_wa)] <= pv_wd;
      end
      if (st_we) begin
         st_mem[st_wa] <= st_wd;
      end
      if (lu_we) begin
         lu_mem[lu_wa] <= frame_ff;
      end
      nx_q       <= nx_mem[rd_addr];
      pv_q       <= pv_mem[rd_addr];
      st_q       <= st_mem[rd_addr];
      lu_q       <= lu_mem[rd_addr];
      nxv_q      <= nxv_ff[rd_addr];
      pvv_q      <= pvv_ff[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = rsp_out_ff;
   assign rsp_buffer_index  = rsp_idx_ff;
   assign rsp_byte_offset   = rsp_off_ff;
   assign rsp_fetch_address = rsp_fetch_ff;
   assign rsp_freed_count   = rsp_freed_ff;

endmodule
